// ===== hw/rtl/fvwo_pkg.sv =====
// shared types and constants for the four-voice wavetable oscillator
// word structs for both channels, request codes, register indexes
// no dependencies
package fvwo_pkg;

  localparam int VOICES    = 4;
  localparam int VOICE_W   = 2;
  localparam int SAMPLE_W  = 16;
  localparam int INDEX_W   = 10;
  localparam int STEP_W    = 26;
  localparam int CFG_IDX_W = 3;

  localparam logic [STEP_W-1:0] STEP_RESET = 26'd65536;

  // request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PORT0_LEFT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PORT0_RIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PORT1_LEFT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PORT1_RIGHT = 3'd3;

  localparam logic [VOICE_W-1:0] LAST_VOICE = 2'd3;

  typedef struct packed {
    logic                       req_type;
    logic        [INDEX_W-1:0]  table_index;
    logic signed [SAMPLE_W-1:0] table_value;
  } req_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] port0_left_sample;
    logic signed [SAMPLE_W-1:0] port0_right_sample;
    logic signed [SAMPLE_W-1:0] port1_left_sample;
    logic signed [SAMPLE_W-1:0] port1_right_sample;
  } rsp_word_t;

  // queue head status seen by the back end
  typedef struct packed {
    logic valid;
    logic tick;
  } head_ctrl_t;

endpackage

// ===== hw/rtl/four_voice_wavetable_oscillator.sv =====
// four-voice wavetable oscillator: a tick word gives four table samples.
// a tick passes the two-word request queue, its voices are read from the
// table one at a time (one single-port table read per voice), then the
// result register loads; table writes go one per cycle unless behind a tick.
// reset: phases clear to zero, steps go to 65536; table contents are
// undefined until written and are not cleared.
module four_voice_wavetable_oscillator #(
  parameter int TABLE_DEPTH   = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  fvwo_pkg::req_word_t               req_word,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output fvwo_pkg::rsp_word_t               rsp_word,
  input  logic                              cfg_we,
  input  logic [fvwo_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fvwo_pkg::STEP_W-1:0]       cfg_data
);
  import fvwo_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [VOICES-1:0][STEP_W-1:0] step;
  head_ctrl_t          head;
  logic [AW-1:0]       head_addr;
  logic [SAMPLE_W-1:0] head_value;
  logic                pop;

  // step registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int v = 0; v < VOICES; v++) step[v] <= STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PORT0_LEFT:  step[0] <= cfg_data;
        REG_PORT0_RIGHT: step[1] <= cfg_data;
        REG_PORT1_LEFT:  step[2] <= cfg_data;
        REG_PORT1_RIGHT: step[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  fvwo_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_word   (req_word),
    .head       (head),
    .head_addr  (head_addr),
    .head_value (head_value),
    .pop        (pop)
  );

  fvwo_back #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_addr  (head_addr),
    .head_value (head_value),
    .pop        (pop),
    .step       (step),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp_word   (rsp_word)
  );

endmodule

// ===== hw/rtl/fvwo_front.sv =====
// front end: takes request words, drops out-of-range writes, queues the rest
// two-entry queue towards the back end
// depends on fvwo_pkg
module fvwo_front #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  fvwo_pkg::req_word_t                 req_word,
  output fvwo_pkg::head_ctrl_t                head,
  output logic [$clog2(TABLE_DEPTH)-1:0]      head_addr,
  output logic [fvwo_pkg::SAMPLE_W-1:0]       head_value,
  input  logic                                pop
);
  import fvwo_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  logic          q_tick  [2];
  logic [AW-1:0] q_addr  [2];
  logic [SAMPLE_W-1:0] q_value [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  logic accept;
  logic in_range;
  logic push;

  // classify: ticks and in-range writes go on, other writes are dropped
  assign accept   = req_valid && !req_stall;
  assign in_range = 32'(req_word.table_index) < TABLE_DEPTH;
  assign push     = accept && (req_word.req_type == REQ_TICK || in_range);
  assign req_stall = (count == 2'd2);

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_tick[wr_ptr]  <= (req_word.req_type == REQ_TICK);
      q_addr[wr_ptr]  <= AW'(req_word.table_index);
      q_value[wr_ptr] <= req_word.table_value;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.tick  = q_tick[rd_ptr];
  assign head_addr  = q_addr[rd_ptr];
  assign head_value = q_value[rd_ptr];

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != 2'd0)
    else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |=> count != 2'd3)
    else $error("queue overfilled");
`endif

endmodule

// ===== hw/rtl/fvwo_back.sv =====
// back end: sample table, four phase accumulators and result register
// one table access per cycle; a started tick reads one voice per cycle
// depends on fvwo_pkg
module fvwo_back #(
  parameter int TABLE_DEPTH   = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  fvwo_pkg::head_ctrl_t                            head,
  input  logic [$clog2(TABLE_DEPTH)-1:0]                  head_addr,
  input  logic [fvwo_pkg::SAMPLE_W-1:0]                   head_value,
  output logic                                            pop,
  input  logic [fvwo_pkg::VOICES-1:0][fvwo_pkg::STEP_W-1:0] step,
  output logic                                            rsp_valid,
  input  logic                                            rsp_stall,
  output fvwo_pkg::rsp_word_t                             rsp_word
);
  import fvwo_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int PW = AW + FRACTION_BITS;
  localparam logic [63:0] WRAP_LIMIT = 64'(TABLE_DEPTH) << FRACTION_BITS;
  localparam logic [PW-1:0] STEP_MAX  = PW'(WRAP_LIMIT - 64'd1);
  localparam logic [PW:0]   WRAP_WIDE = (PW+1)'(WRAP_LIMIT);

  logic [SAMPLE_W-1:0] table_mem [TABLE_DEPTH];
  logic [SAMPLE_W-1:0] sample_slot [VOICES];
  logic [PW-1:0]       phase [VOICES];
  logic [VOICE_W-1:0]  vcnt;
  logic                collect_full;

  logic          out_load;
  logic          slot_free;
  logic          do_write;
  logic          do_read;
  logic [STEP_W-1:0] step_sel;
  logic [PW-1:0] step_c;
  logic [PW:0]   sum;
  logic [PW-1:0] phase_next;
  logic [AW-1:0] rd_addr;

  // result register takes the collected samples when free
  assign out_load  = collect_full && (!rsp_valid || !rsp_stall);
  assign slot_free = !collect_full || out_load;

  // table port use: a write, or one voice read of a tick
  assign do_write = head.valid && !head.tick;
  assign do_read  = head.valid && head.tick && (vcnt != '0 || slot_free);
  assign pop      = do_write || (do_read && vcnt == LAST_VOICE);

  // shared phase update for the voice being read
  assign rd_addr  = phase[vcnt][PW-1 -: AW];
  assign step_sel = step[vcnt];

  always_comb begin
    if (64'(step_sel) >= WRAP_LIMIT) begin
      step_c = STEP_MAX;
    end else begin
      step_c = PW'(step_sel);
    end
    sum = {1'b0, phase[vcnt]} + {1'b0, step_c};
    if (sum >= WRAP_WIDE) begin
      phase_next = PW'(sum - WRAP_WIDE);
    end else begin
      phase_next = PW'(sum);
    end
  end

  // sample table, single port
  always_ff @(posedge clk) begin
    if (do_write) begin
      table_mem[head_addr] <= head_value;
    end else if (do_read) begin
      sample_slot[vcnt] <= table_mem[rd_addr];
    end
  end

  // voice counter, phases and collect status
  always_ff @(posedge clk) begin
    if (rst) begin
      vcnt         <= '0;
      collect_full <= 1'b0;
      for (int v = 0; v < VOICES; v++) phase[v] <= '0;
    end else begin
      if (do_read) begin
        vcnt        <= vcnt + 2'd1;
        phase[vcnt] <= phase_next;
      end
      if (do_read && vcnt == LAST_VOICE) begin
        collect_full <= 1'b1;
      end else if (out_load) begin
        collect_full <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp_word.port0_left_sample  <= sample_slot[0];
      rsp_word.port0_right_sample <= sample_slot[1];
      rsp_word.port1_left_sample  <= sample_slot[2];
      rsp_word.port1_right_sample <= sample_slot[3];
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (do_read && vcnt == '0) |-> slot_free)
    else $error("tick started over an unsent result");
  a_mid_tick_head: assert property (@(posedge clk) disable iff (rst)
    vcnt != '0 |-> (head.valid && head.tick))
    else $error("tick head lost mid sequence");
  a_phase_wrapped: assert property (@(posedge clk) disable iff (rst)
    do_read |=> 64'(phase[$past(vcnt)]) < WRAP_LIMIT)
    else $error("phase beyond table depth");
`endif

endmodule
